// ===== sv/conv2d_zero_pad_filter_unit_macros.svh =====
`ifndef CONV2D_ZERO_PAD_FILTER_UNIT_MACROS_SVH
`define CONV2D_ZERO_PAD_FILTER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define C2DZP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define C2DZP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/c2dzp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package c2dzp_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int MAX_KERNEL_DEF = 9;

  localparam int RST_IMAGE_WIDTH  = 1024;
  localparam int RST_IMAGE_HEIGHT = 1024;
  localparam int RST_KERNEL_SIZE  = 9;

  localparam int OP_W       = 2;
  localparam int COEF_IDX_W = 7;
  localparam int COEF_W     = 8;
  localparam int PIX_W      = 8;
  localparam int OUT_W      = 23;
  localparam int PROD_W     = COEF_W + PIX_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_K_W    = 4;
  localparam int NTAPS      = 81;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_PIXEL = 2'd1,
    OP_FLUSH = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_KERNEL = 2'd2
  } reg_e;

  typedef struct packed {
    logic issue;
    logic in_img;
    logic first;
    logic last;
  } tap_ctrl_t;

  typedef struct packed {
    logic line_we;
    logic coef_we;
  } wr_ctrl_t;

  localparam logic signed [COEF_W-1:0] RESET_TAPS [NTAPS] = '{
    8'sd0, 8'sd1, 8'sd1, 8'sd2, 8'sd2, 8'sd2, 8'sd1, 8'sd1, 8'sd0,
    8'sd1, 8'sd2, 8'sd4, 8'sd5, 8'sd5, 8'sd5, 8'sd4, 8'sd2, 8'sd1,
    8'sd1, 8'sd4, 8'sd5, 8'sd3, 8'sd0, 8'sd3, 8'sd5, 8'sd4, 8'sd1,
    8'sd2, 8'sd5, 8'sd3, -8'sd12, -8'sd24, -8'sd12, 8'sd3, 8'sd5, 8'sd2,
    8'sd2, 8'sd5, 8'sd0, -8'sd24, -8'sd40, -8'sd24, 8'sd0, 8'sd5, 8'sd2,
    8'sd2, 8'sd5, 8'sd3, -8'sd12, -8'sd24, -8'sd12, 8'sd3, 8'sd5, 8'sd2,
    8'sd1, 8'sd4, 8'sd5, 8'sd3, 8'sd0, 8'sd3, 8'sd5, 8'sd4, 8'sd1,
    8'sd1, 8'sd2, 8'sd4, 8'sd5, 8'sd5, 8'sd5, 8'sd4, 8'sd2, 8'sd1,
    8'sd0, 8'sd1, 8'sd1, 8'sd2, 8'sd2, 8'sd2, 8'sd1, 8'sd1, 8'sd0
  };

  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  function automatic logic [COEF_W-1:0] reset_tap(input logic [7:0] idx);
    logic [COEF_W-1:0] val;
    val = '0;
    if (idx < 8'(NTAPS)) begin
      val = RESET_TAPS[7'(idx)];
    end
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== sv/c2dzp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface c2dzp_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [c2dzp_pkg::OP_W-1:0]             op;
  logic [c2dzp_pkg::COEF_IDX_W-1:0]       coef_index;
  logic signed [c2dzp_pkg::COEF_W-1:0]    coef_value;
  logic [c2dzp_pkg::PIX_W-1:0]            pixel;

  modport source (output valid, op, coef_index, coef_value, pixel, input ready);
  modport sink   (input valid, op, coef_index, coef_value, pixel, output ready);
endinterface

interface c2dzp_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [c2dzp_pkg::OUT_W-1:0]     filtered_value;
  logic                                   frame_last;

  modport source (output valid, filtered_value, frame_last, input ready);
  modport sink   (input valid, filtered_value, frame_last, output ready);
endinterface

interface c2dzp_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [c2dzp_pkg::CFG_IDX_W-1:0]        index;
  logic [c2dzp_pkg::CFG_DATA_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/conv2d_zero_pad_filter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// 2-D convolution with zero padding over a row-major 8-bit pixel stream.
// in_chan: one word per op: coefficient load, pixel, or flush step. The result of
// output pixel k leaves on out_chan once pixel k + (K/2)*W + K/2 has arrived; the
// outputs still owed after the last pixel come out one per flush word.
// cfg_chan: width, height and kernel size by index; a write restarts the frame.
// Ready is always high; write only while no word is in flight.
// Timing: after a load, a flush with nothing owed or a pixel that emits nothing, the
// next word can be taken in the following cycle. A word that emits passes a setup step,
// then one kernel tap per cycle through the single read port of the line memory,
// then a three-stage read/multiply/accumulate pipe and the output register.
// Reset: coefficients read as the built-in 9x9 kernel, size registers go to
// 1024 x 1024 x 9, all positions clear; a settle flag keeps in_chan.ready low after
// reset and after each register write. The line memory needs no clearing.
// Stall: a result waits in the output register while the next word is taken;
// a later result waits in its last step until that register frees.

`include "conv2d_zero_pad_filter_unit_macros.svh"

module conv2d_zero_pad_filter_unit #(
  parameter int MAX_WIDTH  = c2dzp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = c2dzp_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_KERNEL = c2dzp_pkg::MAX_KERNEL_DEF
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  c2dzp_in_if.sink     in_chan,
  c2dzp_out_if.source  out_chan,
  c2dzp_cfg_if.sink    cfg_chan
);

  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int KW     = $clog2(MAX_KERNEL + 1);
  localparam int LDEPTH = MAX_KERNEL * MAX_WIDTH;
  localparam int KSTORE = MAX_KERNEL * MAX_KERNEL;
  localparam int LAW    = c2dzp_pkg::addr_w(LDEPTH);
  localparam int CIW    = c2dzp_pkg::addr_w(KSTORE);
  localparam int TW     = $clog2(KSTORE + 1);
  localparam int NW     = $clog2(MAX_WIDTH * MAX_HEIGHT + LDEPTH + 1);
  localparam int SPW    = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT)
                                 + MAX_KERNEL) + 1;
  localparam int OW     = c2dzp_pkg::OUT_W;
  localparam int RST_W  = (c2dzp_pkg::RST_IMAGE_WIDTH > MAX_WIDTH) ?
                          MAX_WIDTH : c2dzp_pkg::RST_IMAGE_WIDTH;
  localparam int RST_H  = (c2dzp_pkg::RST_IMAGE_HEIGHT > MAX_HEIGHT) ?
                          MAX_HEIGHT : c2dzp_pkg::RST_IMAGE_HEIGHT;
  localparam int RST_K  = (c2dzp_pkg::RST_KERNEL_SIZE > MAX_KERNEL) ?
                          MAX_KERNEL : c2dzp_pkg::RST_KERNEL_SIZE;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_TAPS  = 5'b00100,
    ST_WAIT  = 5'b01000,
    ST_PUT   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [WW-1:0]  w_q, w_d;
  logic [HW-1:0]  h_q, h_d;
  logic [KW-1:0]  ksz_q, ksz_d;
  logic [NW-1:0]  lat_q, total_q;
  logic [TW-1:0]  kk_q;
  logic           settle_q, settle_d;
  logic [KW-1:0]  half;

  logic [WW-1:0]  in_col_q, in_col_d;
  logic [HW-1:0]  in_row_q, in_row_d;
  logic [NW-1:0]  p_q, p_d;
  logic [LAW-1:0] wptr_q, wptr_d;
  logic [NW-1:0]  k_q, k_d;
  logic [LAW-1:0] kptr_q, kptr_d;
  logic [HW-1:0]  orow_q, orow_d;
  logic [WW-1:0]  ocol_q, ocol_d;
  logic           draining_q, draining_d;

  logic [LAW-1:0] row_addr_q, row_addr_d;
  logic [LAW-1:0] col_addr_q, col_addr_d;
  logic [SPW-1:0] nr_q, nr_d;
  logic [SPW-1:0] nc_q, nc_d;
  logic [KW-1:0]  ccnt_q, ccnt_d;
  logic [TW-1:0]  tap_idx_q, tap_idx_d;

  logic           out_valid_q, out_valid_d;
  logic [OW-1:0]  out_val_q, out_val_d;
  logic           out_last_q, out_last_d;

  logic           in_ready, in_fire, cfg_fire;
  logic           ended, emit;
  logic [NW-1:0]  k_base;
  logic [LAW:0]   lat_n, kptr_x, start_sum, row_sum;
  logic [LAW-1:0] start_addr, row_next, col_next;
  logic           tap_inside, tap_last, row_end;
  logic [c2dzp_pkg::CFG_DATA_W-1:0] cfg_dim;
  logic [c2dzp_pkg::CFG_K_W-1:0] cfg_k;

  c2dzp_pkg::wr_ctrl_t  wr;
  c2dzp_pkg::tap_ctrl_t tap;
  logic signed [OW-1:0] acc;
  logic                 dp_done;

  assign in_ready       = (state_q == ST_IDLE) && !settle_q;
  assign in_chan.ready  = in_ready;
  assign in_fire        = in_chan.valid && in_ready;
  assign cfg_chan.ready = 1'b1;
  assign cfg_fire       = cfg_chan.valid;
  assign cfg_dim        = cfg_chan.data;
  assign cfg_k          = cfg_chan.data[c2dzp_pkg::CFG_K_W-1:0];

  assign half   = ksz_q >> 1;
  assign ended  = (({1'b0, in_col_q} + 1'b1) >= {1'b0, w_q}) &&
                  (({1'b0, in_row_q} + 1'b1) >= {1'b0, h_q});
  assign emit   = p_q >= lat_q;
  assign k_base = (p_q == '0) ? '0 : k_q;

  assign lat_n      = (LAW+1)'(lat_q);
  assign kptr_x     = {1'b0, kptr_q};
  assign start_sum  = (kptr_x >= lat_n) ? kptr_x - lat_n
                                        : kptr_x + (LAW+1)'(LDEPTH) - lat_n;
  assign start_addr = LAW'(start_sum);
  assign row_sum    = {1'b0, row_addr_q} + (LAW+1)'(w_q);
  assign row_next   = (row_sum >= (LAW+1)'(LDEPTH)) ? LAW'(row_sum - (LAW+1)'(LDEPTH))
                                                    : LAW'(row_sum);
  assign col_next   = (col_addr_q == LAW'(LDEPTH - 1)) ? '0 : col_addr_q + 1'b1;

  assign tap_inside = !nr_q[SPW-1] && (nr_q < SPW'(h_q)) &&
                      !nc_q[SPW-1] && (nc_q < SPW'(w_q));
  assign tap_last   = (tap_idx_q + TW'(1)) == kk_q;
  assign row_end    = (ccnt_q + KW'(1)) == ksz_q;

  always_comb begin
    state_d     = state_q;
    w_d         = w_q;
    h_d         = h_q;
    ksz_d       = ksz_q;
    settle_d    = 1'b0;
    in_col_d    = in_col_q;
    in_row_d    = in_row_q;
    p_d         = p_q;
    wptr_d      = wptr_q;
    k_d         = k_q;
    kptr_d      = kptr_q;
    orow_d      = orow_q;
    ocol_d      = ocol_q;
    draining_d  = draining_q;
    row_addr_d  = row_addr_q;
    col_addr_d  = col_addr_q;
    nr_d        = nr_q;
    nc_d        = nc_q;
    ccnt_d      = ccnt_q;
    tap_idx_d   = tap_idx_q;
    out_valid_d = out_valid_q && !out_chan.ready;
    out_val_d   = out_val_q;
    out_last_d  = out_last_q;
    wr          = '0;
    tap         = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (c2dzp_pkg::op_e'(in_chan.op))
            c2dzp_pkg::OP_LOAD: begin
              wr.coef_we = 32'(in_chan.coef_index) < KSTORE;
            end
            c2dzp_pkg::OP_PIXEL: begin
              wr.line_we = 1'b1;
              if (p_q == '0) begin
                k_d        = '0;
                kptr_d     = '0;
                orow_d     = '0;
                ocol_d     = '0;
                draining_d = 1'b0;
              end
              if (({1'b0, in_col_q} + 1'b1) >= {1'b0, w_q}) begin
                in_col_d = '0;
                in_row_d = ended ? '0 : in_row_q + 1'b1;
              end else begin
                in_col_d = in_col_q + 1'b1;
              end
              if (ended) begin
                p_d        = '0;
                wptr_d     = '0;
                draining_d = emit ? ((k_base + NW'(1)) < total_q) : (k_base < total_q);
              end else begin
                p_d    = p_q + 1'b1;
                wptr_d = (wptr_q == LAW'(LDEPTH - 1)) ? '0 : wptr_q + 1'b1;
              end
              if (emit) begin
                state_d = ST_SETUP;
              end
            end
            c2dzp_pkg::OP_FLUSH: begin
              if (draining_q && (k_q < total_q)) begin
                draining_d = (k_q + NW'(1)) < total_q;
                state_d    = ST_SETUP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SETUP: begin
        row_addr_d = start_addr;
        col_addr_d = start_addr;
        nr_d       = SPW'(orow_q) - SPW'(half);
        nc_d       = SPW'(ocol_q) - SPW'(half);
        ccnt_d     = '0;
        tap_idx_d  = '0;
        state_d    = ST_TAPS;
      end
      ST_TAPS: begin
        tap.issue  = 1'b1;
        tap.in_img = tap_inside;
        tap.first  = tap_idx_q == '0;
        tap.last   = tap_last;
        if (tap_last) begin
          state_d = ST_WAIT;
        end else if (row_end) begin
          ccnt_d     = '0;
          row_addr_d = row_next;
          col_addr_d = row_next;
          nr_d       = nr_q + 1'b1;
          nc_d       = SPW'(ocol_q) - SPW'(half);
          tap_idx_d  = tap_idx_q + 1'b1;
        end else begin
          ccnt_d     = ccnt_q + 1'b1;
          col_addr_d = col_next;
          nc_d       = nc_q + 1'b1;
          tap_idx_d  = tap_idx_q + 1'b1;
        end
      end
      ST_WAIT: begin
        if (dp_done) begin
          state_d = ST_PUT;
        end
      end
      ST_PUT: begin
        if (!out_valid_q || out_chan.ready) begin
          out_valid_d = 1'b1;
          out_val_d   = acc;
          out_last_d  = k_q == (total_q - NW'(1));
          k_d         = k_q + 1'b1;
          kptr_d      = (kptr_q == LAW'(LDEPTH - 1)) ? '0 : kptr_q + 1'b1;
          if (({1'b0, ocol_q} + 1'b1) >= {1'b0, w_q}) begin
            ocol_d = '0;
            orow_d = orow_q + 1'b1;
          end else begin
            ocol_d = ocol_q + 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_fire) begin
      case (c2dzp_pkg::reg_e'(cfg_chan.index))
        c2dzp_pkg::REG_WIDTH: begin
          w_d = (cfg_dim == '0) ? WW'(1) :
                ((32'(cfg_dim) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_dim));
        end
        c2dzp_pkg::REG_HEIGHT: begin
          h_d = (cfg_dim == '0) ? HW'(1) :
                ((32'(cfg_dim) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_dim));
        end
        c2dzp_pkg::REG_KERNEL: begin
          ksz_d = (cfg_k == '0) ? KW'(1) :
                  ((32'(cfg_k) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(cfg_k));
        end
        default: begin
        end
      endcase
      if (cfg_chan.index <= c2dzp_pkg::REG_KERNEL) begin
        settle_d   = 1'b1;
        in_col_d   = '0;
        in_row_d   = '0;
        p_d        = '0;
        wptr_d     = '0;
        k_d        = '0;
        kptr_d     = '0;
        orow_d     = '0;
        ocol_d     = '0;
        draining_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      w_q         <= WW'(RST_W);
      h_q         <= HW'(RST_H);
      ksz_q       <= KW'(RST_K);
      lat_q       <= '0;
      total_q     <= '0;
      kk_q        <= '0;
      settle_q    <= 1'b1;
      in_col_q    <= '0;
      in_row_q    <= '0;
      p_q         <= '0;
      wptr_q      <= '0;
      k_q         <= '0;
      kptr_q      <= '0;
      orow_q      <= '0;
      ocol_q      <= '0;
      draining_q  <= 1'b0;
      row_addr_q  <= '0;
      col_addr_q  <= '0;
      nr_q        <= '0;
      nc_q        <= '0;
      ccnt_q      <= '0;
      tap_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      w_q         <= w_d;
      h_q         <= h_d;
      ksz_q       <= ksz_d;
      lat_q       <= NW'(half) * NW'(w_q) + NW'(half);
      total_q     <= NW'(w_q) * NW'(h_q);
      kk_q        <= TW'(ksz_q) * TW'(ksz_q);
      settle_q    <= settle_d;
      in_col_q    <= in_col_d;
      in_row_q    <= in_row_d;
      p_q         <= p_d;
      wptr_q      <= wptr_d;
      k_q         <= k_d;
      kptr_q      <= kptr_d;
      orow_q      <= orow_d;
      ocol_q      <= ocol_d;
      draining_q  <= draining_d;
      row_addr_q  <= row_addr_d;
      col_addr_q  <= col_addr_d;
      nr_q        <= nr_d;
      nc_q        <= nc_d;
      ccnt_q      <= ccnt_d;
      tap_idx_q   <= tap_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
  end

  assign out_chan.valid          = out_valid_q;
  assign out_chan.filtered_value = out_val_q;
  assign out_chan.frame_last     = out_last_q;

  c2dzp_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (wr),
    .line_waddr_i (wptr_q),
    .pixel_i      (in_chan.pixel),
    .coef_waddr_i (CIW'(in_chan.coef_index)),
    .coef_wdata_i (in_chan.coef_value),
    .tap_i        (tap),
    .line_raddr_i (col_addr_q),
    .coef_raddr_i (CIW'(tap_idx_q)),
    .acc_o        (acc),
    .done_o       (dp_done)
  );

  `C2DZP_ASSERT_NOW(a_put_in_frame, state_q == ST_PUT, k_q < total_q, "output past frame end")
  `C2DZP_ASSERT_NOW(a_last_tap_count, tap.issue && tap.last, (tap_idx_q + TW'(1)) == kk_q, "tap count off")
  `C2DZP_ASSERT_NOW(a_ring_ptr_range, 1'b1, (32'(wptr_q) < LDEPTH) && (32'(kptr_q) < LDEPTH), "ring pointer out of range")
  `C2DZP_ASSERT_NEXT(a_done_only_waiting, dp_done, state_q == ST_PUT, "sum done outside wait")

endmodule

`default_nettype wire

// ===== sv/c2dzp_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "conv2d_zero_pad_filter_unit_macros.svh"

module c2dzp_datapath #(
  parameter int MAX_WIDTH  = c2dzp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_KERNEL = c2dzp_pkg::MAX_KERNEL_DEF,
  localparam int LDEPTH = MAX_KERNEL * MAX_WIDTH,
  localparam int KSTORE = MAX_KERNEL * MAX_KERNEL,
  localparam int LAW    = c2dzp_pkg::addr_w(LDEPTH),
  localparam int CIW    = c2dzp_pkg::addr_w(KSTORE)
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  c2dzp_pkg::wr_ctrl_t                  wr_i,
  input  wire [LAW-1:0]                        line_waddr_i,
  input  wire [c2dzp_pkg::PIX_W-1:0]           pixel_i,
  input  wire [CIW-1:0]                        coef_waddr_i,
  input  wire [c2dzp_pkg::COEF_W-1:0]          coef_wdata_i,
  input  c2dzp_pkg::tap_ctrl_t                 tap_i,
  input  wire [LAW-1:0]                        line_raddr_i,
  input  wire [CIW-1:0]                        coef_raddr_i,
  output logic signed [c2dzp_pkg::OUT_W-1:0]   acc_o,
  output logic                                 done_o
);

  localparam int PRW = c2dzp_pkg::PROD_W;
  localparam int OW  = c2dzp_pkg::OUT_W;

  logic [c2dzp_pkg::PIX_W-1:0]  line_mem [LDEPTH];
  logic [c2dzp_pkg::COEF_W-1:0] coef_mem [KSTORE];
  logic [KSTORE-1:0]            coef_vld_q;

  logic [c2dzp_pkg::PIX_W-1:0]  pix_rd_q;
  logic [c2dzp_pkg::COEF_W-1:0] coef_rd_q;
  logic                         coef_ok_q;
  logic [CIW-1:0]               caddr_q;
  c2dzp_pkg::tap_ctrl_t         ctrl1_q;
  c2dzp_pkg::tap_ctrl_t         ctrl2_q;

  logic [c2dzp_pkg::COEF_W-1:0] coef_sel;
  logic signed [PRW-1:0]        prod_d;
  logic signed [PRW-1:0]        prod_q;
  logic signed [OW-1:0]         prod_x;
  logic signed [OW-1:0]         acc_q;
  logic                         done_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.line_we) begin
      line_mem[line_waddr_i] <= pixel_i;
    end
    if (tap_i.issue) begin
      pix_rd_q <= line_mem[line_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.coef_we) begin
      coef_mem[coef_waddr_i] <= coef_wdata_i;
    end
    if (tap_i.issue) begin
      coef_rd_q <= coef_mem[coef_raddr_i];
      caddr_q   <= coef_raddr_i;
    end
  end

  // entries never loaded read as the built-in kernel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_vld_q <= '0;
      coef_ok_q  <= 1'b0;
    end else begin
      if (wr_i.coef_we) begin
        coef_vld_q[coef_waddr_i] <= 1'b1;
      end
      if (tap_i.issue) begin
        coef_ok_q <= coef_vld_q[coef_raddr_i];
      end
    end
  end

  assign coef_sel = coef_ok_q ? coef_rd_q : c2dzp_pkg::reset_tap(8'(caddr_q));
  assign prod_d   = ctrl1_q.in_img ?
                    PRW'($signed(coef_sel)) * PRW'($signed({1'b0, pix_rd_q})) : '0;
  assign prod_x   = {{(OW-PRW){prod_q[PRW-1]}}, prod_q};

  always_ff @(posedge clk_i) begin
    if (ctrl1_q.issue) begin
      prod_q <= prod_d;
    end
    if (ctrl2_q.issue) begin
      acc_q <= ctrl2_q.first ? prod_x : acc_q + prod_x;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl1_q <= '0;
      ctrl2_q <= '0;
      done_q  <= 1'b0;
    end else begin
      ctrl1_q <= tap_i;
      ctrl2_q <= ctrl1_q;
      done_q  <= ctrl2_q.issue && ctrl2_q.last;
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

  `C2DZP_ASSERT_NOW(a_no_line_rw_overlap, wr_i.line_we, !tap_i.issue, "line write during tap read")
  `C2DZP_ASSERT_NEXT(a_done_after_last, ctrl2_q.issue && ctrl2_q.last, done_o, "sum not marked done")
  `C2DZP_ASSERT_NEXT(a_pad_is_zero, ctrl1_q.issue && !ctrl1_q.in_img, prod_q == '0, "pad tap nonzero")

endmodule

`default_nettype wire
